// ===== design/gvc_pkg.sv =====
// Shared types and constants for the greedy vertex coloring unit.
// Used by gvc_core and greedy_vertex_coloring_unit; no dependencies.
`default_nettype none

package gvc_pkg;

  localparam int MAX_NODES_DEF = 64;   // default graph size limit
  localparam int ROW_W         = 64;   // adjacency row width
  localparam int COLOR_W       = 6;    // color and vertex index width
  localparam int VCOUNT_W      = 7;    // vertex_count / color_count width

  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 7'd64;

  // APB register map: one 32-bit register per word
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;

  typedef struct packed {
    logic [VCOUNT_W-1:0] vertex_count;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK
  } state_t;

endpackage

`default_nettype wire

// ===== design/gvc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/gvc_core.sv =====
// Coloring sequencer: scans earlier neighbors' colors one per cycle from the
// color store, then picks the lowest free color. Depends on gvc_pkg, gvc_ram.
`default_nettype none

module gvc_core #(
  parameter int MAX_NODES = gvc_pkg::MAX_NODES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire gvc_pkg::cfg_t                cfg,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic [gvc_pkg::ROW_W-1:0]    neighbours,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [gvc_pkg::COLOR_W-1:0]  vertex_index,
  output      logic [gvc_pkg::COLOR_W-1:0]  color,
  output      logic                         is_last,
  output      logic [gvc_pkg::VCOUNT_W-1:0] color_count
);
  import gvc_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  localparam logic [VCOUNT_W-1:0] MAX_CNT = VCOUNT_W'(MAX_NODES);

  state_t state, state_next;

  logic [MAX_NODES-1:0] row;
  logic [MAX_NODES-1:0] used;
  logic [AW-1:0]        cur_v;
  logic [AW-1:0]        next_vertex;
  logic [AW-1:0]        highest;
  logic [AW-1:0]        rd_idx;
  logic [AW-1:0]        rd_j;
  logic                 rd_pend;
  logic [COLOR_W-1:0]   rdata;

  logic                 accept;
  logic                 out_free;
  logic                 finish;
  logic [AW-1:0]        pick;
  logic [AW-1:0]        hi_next;
  logic [VCOUNT_W-1:0]  eff_cnt;
  logic                 last;

  gvc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MAX_NODES)
  ) u_store (
    .clk   (clk),
    .we    (finish),
    .waddr (cur_v),
    .wdata (COLOR_W'(pick)),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // lowest color not marked by a neighbor
  always_comb begin
    pick = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        pick = AW'(i);
      end
    end
  end

  always_comb begin
    if (cfg.vertex_count == '0) begin
      eff_cnt = VCOUNT_W'(1);
    end else if (cfg.vertex_count > MAX_CNT) begin
      eff_cnt = MAX_CNT;
    end else begin
      eff_cnt = cfg.vertex_count;
    end
  end

  assign last    = (VCOUNT_W'(cur_v) + VCOUNT_W'(1)) >= eff_cnt;
  assign hi_next = ((cur_v == '0) || (pick > highest)) ? pick : highest;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (next_vertex == '0) ? ST_PICK : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx == cur_v - AW'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // scan datapath: store read data is registered and arrives the cycle after its address
  always_ff @(posedge clk) begin
    if (accept) begin
      row    <= neighbours[MAX_NODES-1:0];
      cur_v  <= next_vertex;
      used   <= '0;
      rd_idx <= '0;
    end else if (state == ST_SCAN) begin
      rd_idx <= rd_idx + AW'(1);
    end
    rd_j <= rd_idx;
    if (rd_pend && row[rd_j]) begin
      used[rdata[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend     <= 1'b0;
      next_vertex <= '0;
      highest     <= '0;
      out_valid   <= 1'b0;
    end else begin
      rd_pend <= (state == ST_SCAN);
      if (finish) begin
        next_vertex <= last ? '0 : cur_v + AW'(1);
        highest     <= last ? '0 : hi_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      vertex_index <= COLOR_W'(cur_v);
      color        <= COLOR_W'(pick);
      is_last      <= last;
      color_count  <= VCOUNT_W'(hi_next) + VCOUNT_W'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_pick_free: assert property (@(posedge clk) disable iff (rst)
    finish |-> !used[pick])
    else $error("picked color is marked used");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_idx < cur_v))
    else $error("scan index past current vertex");

  a_count_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (color_count > VCOUNT_W'(color)))
    else $error("color count does not cover emitted color");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (finish && last) |=> (next_vertex == '0) && (highest == '0))
    else $error("graph state not cleared after last vertex");
`endif

endmodule

`default_nettype wire

// ===== design/greedy_vertex_coloring_unit.sv =====
// Top level of the greedy vertex coloring unit: APB register and core.
// Depends on gvc_pkg and gvc_core (which uses gvc_ram).
//
// Usage: each request on the input channel (in_valid/in_stall, neighbours)
// is the adjacency row of the next vertex of the current graph. Each one
// yields exactly one result on the output channel (out_valid/out_stall):
// vertex_index, color, is_last and color_count. The vertex whose index
// plus one reaches vertex_count is flagged is_last and the next request
// starts a new graph at vertex 0.
// Sequence: for vertex v > 0 the earlier colors are read back from the color
// store one per cycle, then a drain step, a priority pick and a store write
// follow; vertex 0 goes straight to the pick. in_stall is high while a
// vertex is being worked on; the next request is taken the cycle after the
// result is registered.
// A stalled result holds in the output register; the next vertex may be
// accepted and scanned meanwhile but waits to finish until the slot frees.
// Reset clears the vertex counter, the highest color, and sets
// vertex_count to 64; the color store needs no clearing pass.
// vertex_count (APB offset 0) should be written only while idle.
`default_nettype none

module greedy_vertex_coloring_unit #(
  parameter int MAX_NODES = gvc_pkg::MAX_NODES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [gvc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [gvc_pkg::APB_DATA_W-1:0] pwdata,
  output      logic [gvc_pkg::APB_DATA_W-1:0] prdata,
  output      logic                           pready,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [gvc_pkg::ROW_W-1:0]      neighbours,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [gvc_pkg::COLOR_W-1:0]    vertex_index,
  output      logic [gvc_pkg::COLOR_W-1:0]    color,
  output      logic                           is_last,
  output      logic [gvc_pkg::VCOUNT_W-1:0]   color_count
);
  import gvc_pkg::*;

  cfg_t                 cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vertex_count <= VCOUNT_RST;
    end else if (wr_en && (reg_idx == REG_VERTEX_COUNT)) begin
      cfg.vertex_count <= pwdata[VCOUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_VERTEX_COUNT) begin
      prdata = APB_DATA_W'(cfg.vertex_count);
    end
  end

  gvc_core #(
    .MAX_NODES (MAX_NODES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .neighbours   (neighbours),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vertex_index (vertex_index),
    .color        (color),
    .is_last      (is_last),
    .color_count  (color_count)
  );

endmodule

`default_nettype wire
